[hdl/vrot_pkg.sv]
// Shared constants for the CORDIC vector rotator.
package vrot_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int ITERATIONS   = 16;

	// internal fixed point: angle is a 32-bit binary angle, pi = 2^31
	localparam int ANG_BITS     = 32;
	localparam int GUARD_BITS   = 24;
	localparam int GAIN_FRAC    = 30;
	localparam int ATAN_ENTRIES = 24;

	// 1/K of the CORDIC, Q30
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;

	// atan(2^-i), full turn = 2^32
	localparam logic [ANG_BITS-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

[hdl/vrot_in_if.sv]
// Input channel: vector and rotation angle.
interface vrot_in_if #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = vrot_pkg::ANGLE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vec_x;
	logic signed [COORD_WIDTH-1:0] vec_y;
	logic signed [ANGLE_WIDTH-1:0] turn_angle;

	modport source (output valid, output vec_x, output vec_y, output turn_angle, input ready);
	modport sink   (input valid, input vec_x, input vec_y, input turn_angle, output ready);
endinterface

[hdl/vrot_out_if.sv]
// Output channel: rotated vector.
interface vrot_out_if #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_WIDTH:0] rot_x;
	logic signed [COORD_WIDTH:0] rot_y;

	modport source (output valid, output rot_x, output rot_y, input ready);
	modport sink   (input valid, input rot_x, input rot_y, output ready);
endinterface

[hdl/vrot_prep.sv]
// Front end: quadrant fold, then gain compensation multiply.
module vrot_prep #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = vrot_pkg::ANGLE_WIDTH,
	parameter int WORK_WIDTH  = COORD_WIDTH + vrot_pkg::GUARD_BITS + 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	output logic                                ready_out,
	input  logic signed [COORD_WIDTH-1:0]       vec_x,
	input  logic signed [COORD_WIDTH-1:0]       vec_y,
	input  logic signed [ANGLE_WIDTH-1:0]       turn_angle,
	output logic                                valid_out,
	input  logic                                ready_in,
	output logic signed [WORK_WIDTH-1:0]        x_out,
	output logic signed [WORK_WIDTH-1:0]        y_out,
	output logic [vrot_pkg::ANG_BITS-1:0]       a_out,
	output logic [1:0]                          occupancy
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int PW = EW + 32;
	localparam int GAIN_SHIFT = vrot_pkg::GAIN_FRAC - vrot_pkg::GUARD_BITS;

	logic [vrot_pkg::ANG_BITS-1:0] a_in;
	logic                          fold;
	logic signed [EW-1:0]          x_ext, y_ext;

	logic                          v_s1, v_s2;
	logic signed [EW-1:0]          x_s1, y_s1;
	logic [vrot_pkg::ANG_BITS-1:0] a_s1;
	logic signed [PW-1:0]          px, py, sx, sy;
	logic                          rdy_s1, rdy_s2;

	assign a_in  = {turn_angle, {(vrot_pkg::ANG_BITS - ANGLE_WIDTH){1'b0}}};
	// angle at or beyond +pi/2, or below -pi/2: turn the vector by pi, angle by pi
	assign fold  = a_in[vrot_pkg::ANG_BITS-1] ^ a_in[vrot_pkg::ANG_BITS-2];
	assign x_ext = {vec_x[COORD_WIDTH-1], vec_x};
	assign y_ext = {vec_y[COORD_WIDTH-1], vec_y};

	assign rdy_s2    = !v_s2 || ready_in;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign ready_out = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && valid_in) begin
			x_s1 <= fold ? -x_ext : x_ext;
			y_s1 <= fold ? -y_ext : y_ext;
			a_s1 <= {a_in[vrot_pkg::ANG_BITS-1] ^ fold, a_in[vrot_pkg::ANG_BITS-2:0]};
		end
	end

	assign px = PW'(x_s1) * $signed({1'b0, vrot_pkg::GAIN_Q30});
	assign py = PW'(y_s1) * $signed({1'b0, vrot_pkg::GAIN_Q30});
	assign sx = px >>> GAIN_SHIFT;
	assign sy = py >>> GAIN_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			x_out <= sx[WORK_WIDTH-1:0];
			y_out <= sy[WORK_WIDTH-1:0];
			a_out <= a_s1;
		end
	end

	assign valid_out = v_s2;
	assign occupancy = {v_s2, v_s1};
endmodule

[hdl/vrot_cell.sv]
// One CORDIC micro-rotation stage.
module vrot_cell #(
	parameter int WORK_WIDTH = vrot_pkg::COORD_WIDTH + vrot_pkg::GUARD_BITS + 3,
	parameter int STAGE      = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	output logic                          ready_out,
	input  logic signed [WORK_WIDTH-1:0]  x_in,
	input  logic signed [WORK_WIDTH-1:0]  y_in,
	input  logic [vrot_pkg::ANG_BITS-1:0] a_in,
	output logic                          valid_out,
	input  logic                          ready_in,
	output logic signed [WORK_WIDTH-1:0]  x_out,
	output logic signed [WORK_WIDTH-1:0]  y_out,
	output logic [vrot_pkg::ANG_BITS-1:0] a_out
);
	logic                          v_q;
	logic                          neg;
	logic signed [WORK_WIDTH-1:0]  dx, dy;

	assign ready_out = !v_q || ready_in;
	assign neg = a_in[vrot_pkg::ANG_BITS-1];
	assign dx  = y_in >>> STAGE;
	assign dy  = x_in >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_out) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_in) begin
			if (neg) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				a_out <= a_in + vrot_pkg::ATAN_TAB[STAGE];
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				a_out <= a_in - vrot_pkg::ATAN_TAB[STAGE];
			end
		end
	end

	assign valid_out = v_q;
endmodule

[hdl/vrot_finish.sv]
// Output stage: drop guard bits toward zero, saturate, hold the result.
module vrot_finish #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH,
	parameter int WORK_WIDTH  = COORD_WIDTH + vrot_pkg::GUARD_BITS + 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_in,
	output logic                         ready_out,
	input  logic signed [WORK_WIDTH-1:0] x_in,
	input  logic signed [WORK_WIDTH-1:0] y_in,
	output logic                         valid_out,
	input  logic                         ready_in,
	output logic signed [COORD_WIDTH:0]  rot_x,
	output logic signed [COORD_WIDTH:0]  rot_y
);
	localparam int G  = vrot_pkg::GUARD_BITS;
	localparam int RW = WORK_WIDTH - G;
	localparam logic signed [RW-1:0] LIM = {{(RW - COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

	logic                        v_q;
	logic signed [WORK_WIDTH-1:0] bx, by, tx, ty;
	logic signed [RW-1:0]        rx, ry, cx, cy;

	// negative values get a bias so the shift rounds toward zero
	assign bx = x_in + {{(WORK_WIDTH - G){1'b0}}, {G{x_in[WORK_WIDTH-1]}}};
	assign by = y_in + {{(WORK_WIDTH - G){1'b0}}, {G{y_in[WORK_WIDTH-1]}}};
	assign tx = bx >>> G;
	assign ty = by >>> G;
	assign rx = tx[RW-1:0];
	assign ry = ty[RW-1:0];

	always_comb begin
		cx = rx;
		if (rx > LIM) begin
			cx = LIM;
		end else if (rx < -LIM) begin
			cx = -LIM;
		end
		cy = ry;
		if (ry > LIM) begin
			cy = LIM;
		end else if (ry < -LIM) begin
			cy = -LIM;
		end
	end

	assign ready_out = !v_q || ready_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_out) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_in) begin
			rot_x <= cx[COORD_WIDTH:0];
			rot_y <= cy[COORD_WIDTH:0];
		end
	end

	assign valid_out = v_q;
endmodule

[hdl/vector_rotate_by_angle_top.sv]
// Throughput: one transaction per cycle while the output takes results; fold, gain
// multiply, one cell per micro-rotation and the output stage each hold one vector,
// and every stage is a register with its own ready.
// A stalled output only stops stages that are full; empty stages keep accepting.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data registers are not reset.
module vector_rotate_by_angle_top #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = vrot_pkg::ANGLE_WIDTH,
	parameter int ITERATIONS  = vrot_pkg::ITERATIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	vrot_in_if.sink     vec,
	vrot_out_if.source  rot
);
	localparam int W = COORD_WIDTH + vrot_pkg::GUARD_BITS + 3;
	localparam int N = (ITERATIONS < vrot_pkg::ATAN_ENTRIES) ? ITERATIONS
		: vrot_pkg::ATAN_ENTRIES;

	logic                          v_c [N+1];
	logic                          r_c [N+1];
	logic signed [W-1:0]           x_c [N+1];
	logic signed [W-1:0]           y_c [N+1];
	logic [vrot_pkg::ANG_BITS-1:0] a_c [N+1];
	logic [1:0]                    prep_occ;
	logic [N-1:0]                  cell_v;

	vrot_prep #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.WORK_WIDTH (W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vec.valid),
		.ready_out (vec.ready),
		.vec_x     (vec.vec_x),
		.vec_y     (vec.vec_y),
		.turn_angle(vec.turn_angle),
		.valid_out (v_c[0]),
		.ready_in  (r_c[0]),
		.x_out     (x_c[0]),
		.y_out     (y_c[0]),
		.a_out     (a_c[0]),
		.occupancy (prep_occ)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		vrot_cell #(
			.WORK_WIDTH(W),
			.STAGE     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (v_c[i]),
			.ready_out(r_c[i]),
			.x_in     (x_c[i]),
			.y_in     (y_c[i]),
			.a_in     (a_c[i]),
			.valid_out(v_c[i+1]),
			.ready_in (r_c[i+1]),
			.x_out    (x_c[i+1]),
			.y_out    (y_c[i+1]),
			.a_out    (a_c[i+1])
		);
		assign cell_v[i] = v_c[i+1];
	end

	vrot_finish #(
		.COORD_WIDTH(COORD_WIDTH),
		.WORK_WIDTH (W)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (v_c[N]),
		.ready_out(r_c[N]),
		.x_in     (x_c[N]),
		.y_in     (y_c[N]),
		.valid_out(rot.valid),
		.ready_in (rot.ready),
		.rot_x    (rot.rot_x),
		.rot_y    (rot.rot_y)
	);

	// input may only back up when every stage holds a vector
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> ($countones({prep_occ, cell_v, rot.valid}) == N + 3))
		else $error("input blocked with an empty pipeline stage");

	a_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		rot.valid |-> (rot.rot_x != {1'b1, {COORD_WIDTH{1'b0}}}))
		else $error("rot_x beyond saturation limit");

	a_sat_y: assert property (@(posedge clk) disable iff (!arst_n)
		rot.valid |-> (rot.rot_y != {1'b1, {COORD_WIDTH{1'b0}}}))
		else $error("rot_y beyond saturation limit");

	// a free output stage must pass the last cell's vector on
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_c[N] && !rot.valid) |=> rot.valid)
		else $error("result lost between last cell and output");
endmodule
